>>> hdl/pedal_to_torque_map_defines.svh
// Assertion macros shared by the pedal-to-torque map checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef PEDAL_TO_TORQUE_MAP_DEFINES_SVH
`define PEDAL_TO_TORQUE_MAP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ptm_pkg.sv
// Shared constants, zone and register codes, and sideband type of the pedal-to-torque map.
// Depends on nothing; used by the divider, the top level and the checker.
package ptm_pkg;

    localparam int PEDAL_FRAC_BITS = 15;
    localparam int TORQUE_WIDTH    = 16;

    localparam int PEDAL_W   = PEDAL_FRAC_BITS + 2;
    localparam int EDGE_W    = PEDAL_FRAC_BITS + 1;
    localparam int WIDE_W    = TORQUE_WIDTH + EDGE_W;
    localparam int EXT_W     = TORQUE_WIDTH + 2;
    localparam int CFG_W     = (EDGE_W > TORQUE_WIDTH) ? EDGE_W : TORQUE_WIDTH;
    localparam int CFG_IDX_W = 3;

    localparam logic [EDGE_W-1:0] PEDAL_FULL = {1'b1, {PEDAL_FRAC_BITS{1'b0}}};
    localparam logic [EDGE_W-1:0] ACCEL_FULL_RESET = {1'b1, {PEDAL_FRAC_BITS{1'b0}}};
    localparam logic [EXT_W-1:0]  TORQUE_MAX = {3'b000, {(TORQUE_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        ZONE_REST        = 3'd0,
        ZONE_REGEN_FULL  = 3'd1,
        ZONE_REGEN_RAMP  = 3'd2,
        ZONE_COAST       = 3'd3,
        ZONE_ACCEL_RAMP  = 3'd4,
        ZONE_ACCEL_FULL  = 3'd5
    } zone_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REST_THRESHOLD  = 3'd0,
        REG_REGEN_FULL_EDGE = 3'd1,
        REG_COAST_LOW_EDGE  = 3'd2,
        REG_COAST_HIGH_EDGE = 3'd3,
        REG_ACCEL_FULL_EDGE = 3'd4,
        REG_REGEN_LIMIT     = 3'd5,
        REG_DRIVE_LIMIT     = 3'd6
    } cfg_reg_t;

    // Travels alongside the ramp arithmetic: the zone and the sign of the ramp result.
    typedef struct packed {
        zone_t zone;
        logic  neg;
    } ptm_side_t;

endpackage

>>> hdl/ptm_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that rides along.
// Depends on ptm_pkg for widths and the sideband type.
module ptm_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ptm_pkg::WIDE_W-1:0]       in_num,
    input  logic [ptm_pkg::EDGE_W-1:0]       in_den,
    input  ptm_pkg::ptm_side_t               in_side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ptm_pkg::TORQUE_WIDTH-1:0] out_quo,
    output ptm_pkg::ptm_side_t               out_side
);

    localparam int STAGES = ptm_pkg::TORQUE_WIDTH;
    localparam int QW     = ptm_pkg::TORQUE_WIDTH;
    localparam int WW     = ptm_pkg::WIDE_W;
    localparam int DW     = ptm_pkg::EDGE_W;

    logic               v_reg    [STAGES];
    logic               rdy      [STAGES];
    logic [WW-1:0]      rem_reg  [STAGES];
    logic [DW-1:0]      den_reg  [STAGES];
    logic [QW-1:0]      quo_reg  [STAGES];
    ptm_pkg::ptm_side_t side_reg [STAGES];

    // The quotient is known to stay below 2^QW, so the search starts at bit QW-1.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic               vin;
        logic [WW-1:0]      rem_in;
        logic [DW-1:0]      den_in;
        logic [QW-1:0]      quo_in;
        ptm_pkg::ptm_side_t side_in;
        logic [WW-1:0]      sub_d;
        logic [WW:0]        diff;
        logic               take;

        if (k == 0) begin : g_first
            assign vin     = in_valid;
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign vin     = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        if (k == STAGES - 1) begin : g_rdy_last
            assign rdy[k] = !v_reg[k] || out_ready;
        end else begin : g_rdy_mid
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end

        assign sub_d = {{QW{1'b0}}, den_in} << (STAGES - 1 - k);
        assign diff  = {1'b0, rem_in} - {1'b0, sub_d};
        assign take  = !diff[WW];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && vin) begin
                rem_reg[k]  <= take ? diff[WW-1:0] : rem_in;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= {quo_in[QW-2:0], take};
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

>>> hdl/pedal_to_torque_map.sv
// Top level of the pedal-to-torque map: config registers, clamp, zone select, ramp multiply,
// divider and envelope clamp. Depends on ptm_pkg and ptm_divider.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_pedal_position (17 b, signed)
//   m_       out        m_valid / m_ready    m_torque_command (16 b, signed), m_pedal_zone (3 b)
//   cfg_     in         cfg_wr_en            cfg_index (3 b), cfg_wdata (16 b)
//
// One beat is accepted per cycle while the output is not stalled; a result passes through the
// clamp, zone select and multiply stages, the divider, which resolves one quotient bit per
// stage (16 stages), and the output stage. Every stage holds its own valid bit, so bubbles
// close up and a stalled output only holds stages that are full. Reset is synchronous, clears
// valid bits and config registers, but sets the accel full edge to full scale.
module pedal_to_torque_map (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [ptm_pkg::PEDAL_W-1:0]      s_pedal_position,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [ptm_pkg::TORQUE_WIDTH-1:0] m_torque_command,
    output logic [2:0]                              m_pedal_zone,
    input  logic                                    cfg_wr_en,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ptm_pkg::CFG_W-1:0]               cfg_wdata
);

    localparam int EW = ptm_pkg::EDGE_W;
    localparam int TW = ptm_pkg::TORQUE_WIDTH;
    localparam int WW = ptm_pkg::WIDE_W;
    localparam int XW = ptm_pkg::EXT_W;

    // Configuration registers.
    logic [EW-1:0]        rest_reg;
    logic [EW-1:0]        rfull_reg;
    logic [EW-1:0]        clo_reg;
    logic [EW-1:0]        chi_reg;
    logic [EW-1:0]        afull_reg;
    logic signed [TW-1:0] regen_lim_reg;
    logic signed [TW-1:0] drive_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_reg      <= '0;
            rfull_reg     <= '0;
            clo_reg       <= '0;
            chi_reg       <= '0;
            afull_reg     <= ptm_pkg::ACCEL_FULL_RESET;
            regen_lim_reg <= '0;
            drive_lim_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ptm_pkg::REG_REST_THRESHOLD:  rest_reg      <= cfg_wdata[EW-1:0];
                ptm_pkg::REG_REGEN_FULL_EDGE: rfull_reg     <= cfg_wdata[EW-1:0];
                ptm_pkg::REG_COAST_LOW_EDGE:  clo_reg       <= cfg_wdata[EW-1:0];
                ptm_pkg::REG_COAST_HIGH_EDGE: chi_reg       <= cfg_wdata[EW-1:0];
                ptm_pkg::REG_ACCEL_FULL_EDGE: afull_reg     <= cfg_wdata[EW-1:0];
                ptm_pkg::REG_REGEN_LIMIT:     regen_lim_reg <= cfg_wdata[TW-1:0];
                ptm_pkg::REG_DRIVE_LIMIT:     drive_lim_reg <= cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // Ready chain, from the output back to the input.
    logic o_rdy;
    logic c_rdy;
    logic b_rdy;
    logic a_rdy;
    logic div_in_ready;

    // Stage A: clamp the pedal to 0..full scale.
    logic          a_v_reg;
    logic [EW-1:0] a_p_reg;
    logic [EW-1:0] a_p_next;

    always_comb begin
        if (s_pedal_position[ptm_pkg::PEDAL_W-1]) begin
            a_p_next = '0;
        end else if (s_pedal_position[EW-1:0] > ptm_pkg::PEDAL_FULL) begin
            a_p_next = ptm_pkg::PEDAL_FULL;
        end else begin
            a_p_next = s_pedal_position[EW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (a_rdy) begin
            a_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && s_valid) begin
            a_p_reg <= a_p_next;
        end
    end

    // Stage B: zone select, ramp operands and limit magnitude.
    logic               b_v_reg;
    ptm_pkg::ptm_side_t b_side_reg;
    logic [EW-1:0]      b_diff_reg;
    logic [EW-1:0]      b_den_reg;
    logic [TW-1:0]      b_mag_reg;
    ptm_pkg::ptm_side_t b_side_next;
    logic [EW-1:0]      b_diff_next;
    logic [EW-1:0]      b_den_next;
    logic [TW-1:0]      b_mag_next;

    always_comb begin
        b_side_next.neg  = 1'b0;
        b_diff_next      = '0;
        b_den_next       = '1;
        b_mag_next       = '0;
        priority if (a_p_reg < rest_reg) begin
            b_side_next.zone = ptm_pkg::ZONE_REST;
        end else if (a_p_reg <= rfull_reg) begin
            b_side_next.zone = ptm_pkg::ZONE_REGEN_FULL;
        end else if (a_p_reg <= clo_reg) begin
            b_side_next.zone = ptm_pkg::ZONE_REGEN_RAMP;
            b_side_next.neg  = regen_lim_reg[TW-1];
            b_diff_next      = clo_reg - a_p_reg;
            b_den_next       = clo_reg - rfull_reg;
            b_mag_next       = regen_lim_reg[TW-1] ? (~regen_lim_reg + 1'b1) : regen_lim_reg;
        end else if (a_p_reg <= chi_reg) begin
            b_side_next.zone = ptm_pkg::ZONE_COAST;
        end else if (a_p_reg <= afull_reg) begin
            b_side_next.zone = ptm_pkg::ZONE_ACCEL_RAMP;
            b_side_next.neg  = drive_lim_reg[TW-1];
            b_diff_next      = a_p_reg - chi_reg;
            b_den_next       = afull_reg - chi_reg;
            b_mag_next       = drive_lim_reg[TW-1] ? (~drive_lim_reg + 1'b1) : drive_lim_reg;
        end else begin
            b_side_next.zone = ptm_pkg::ZONE_ACCEL_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (b_rdy) begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_rdy && a_v_reg) begin
            b_side_reg <= b_side_next;
            b_diff_reg <= b_diff_next;
            b_den_reg  <= b_den_next;
            b_mag_reg  <= b_mag_next;
        end
    end

    // Stage C: exact product of limit magnitude and pedal distance.
    logic               c_v_reg;
    ptm_pkg::ptm_side_t c_side_reg;
    logic [WW-1:0]      c_num_reg;
    logic [EW-1:0]      c_den_reg;
    logic [WW-1:0]      c_num_next;

    assign c_num_next = {{EW{1'b0}}, b_mag_reg} * {{TW{1'b0}}, b_diff_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (c_rdy) begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_rdy && b_v_reg) begin
            c_side_reg <= b_side_reg;
            c_num_reg  <= c_num_next;
            c_den_reg  <= b_den_reg;
        end
    end

    // Divider.
    logic               d_valid;
    logic [TW-1:0]      d_quo;
    ptm_pkg::ptm_side_t d_side;

    ptm_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_v_reg),
        .in_ready  (div_in_ready),
        .in_num    (c_num_reg),
        .in_den    (c_den_reg),
        .in_side   (c_side_reg),
        .out_valid (d_valid),
        .out_ready (o_rdy),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    // Output stage: apply sign, envelope clamp and symmetric saturation.
    logic                 m_valid_reg;
    logic signed [TW-1:0] torque_reg;
    logic [2:0]           zone_reg;
    logic signed [TW-1:0] torque_next;

    logic signed [XW-1:0] q_ext;
    logic signed [XW-1:0] regen_ext;
    logic signed [XW-1:0] drive_ext;
    logic signed [XW-1:0] floor_t;
    logic signed [XW-1:0] ceil_t;
    logic signed [XW-1:0] t_raw;
    logic signed [XW-1:0] t_lo;
    logic signed [XW-1:0] t_hi;
    logic signed [XW-1:0] t_sat;

    assign q_ext     = $signed({2'b00, d_quo});
    assign regen_ext = $signed({{2{regen_lim_reg[TW-1]}}, regen_lim_reg});
    assign drive_ext = $signed({{2{drive_lim_reg[TW-1]}}, drive_lim_reg});
    assign floor_t   = regen_ext[XW-1] ? regen_ext : -regen_ext;
    assign ceil_t    = drive_ext[XW-1] ? -drive_ext : drive_ext;

    always_comb begin
        unique case (d_side.zone)
            ptm_pkg::ZONE_REGEN_FULL: t_raw = regen_ext;
            ptm_pkg::ZONE_REGEN_RAMP,
            ptm_pkg::ZONE_ACCEL_RAMP: t_raw = d_side.neg ? -q_ext : q_ext;
            ptm_pkg::ZONE_ACCEL_FULL: t_raw = drive_ext;
            default:                  t_raw = '0;
        endcase
        t_lo = (t_raw < floor_t) ? floor_t : t_raw;
        t_hi = (t_lo > ceil_t) ? ceil_t : t_lo;
        if (t_hi > $signed(ptm_pkg::TORQUE_MAX)) begin
            t_sat = $signed(ptm_pkg::TORQUE_MAX);
        end else if (t_hi < -$signed(ptm_pkg::TORQUE_MAX)) begin
            t_sat = -$signed(ptm_pkg::TORQUE_MAX);
        end else begin
            t_sat = t_hi;
        end
        torque_next = t_sat[TW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_rdy) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_rdy && d_valid) begin
            torque_reg <= torque_next;
            zone_reg   <= d_side.zone;
        end
    end

    assign o_rdy = !m_valid_reg || m_ready;
    assign c_rdy = !c_v_reg || div_in_ready;
    assign b_rdy = !b_v_reg || c_rdy;
    assign a_rdy = !a_v_reg || b_rdy;

    assign s_ready          = a_rdy;
    assign m_valid          = m_valid_reg;
    assign m_torque_command = torque_reg;
    assign m_pedal_zone     = zone_reg;

endmodule

>>> hdl/ptm_checker.sv
// Port-level checks on the pedal-to-torque map, bound to the top level.
// Depends on ptm_pkg and the macros in pedal_to_torque_map_defines.svh.
`include "pedal_to_torque_map_defines.svh"

module ptm_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [ptm_pkg::TORQUE_WIDTH-1:0] m_torque_command,
    input logic [2:0]                              m_pedal_zone
);

    localparam int TW = ptm_pkg::TORQUE_WIDTH;

    // No result may appear in the first cycle after reset is released.
    `PTM_ASSERT_SAME(a_quiet_after_reset, aclk, aresetn, !$past(aresetn), !m_valid, "result beat right after reset")

    // Only the six defined zone codes may leave the block.
    `PTM_ASSERT_SAME(a_zone_code, aclk, aresetn, m_valid, m_pedal_zone <= ptm_pkg::ZONE_ACCEL_FULL, "undefined pedal zone code")

    // The dead zones always command zero torque.
    `PTM_ASSERT_SAME(a_dead_zone_zero, aclk, aresetn, m_valid && (m_pedal_zone == ptm_pkg::ZONE_REST || m_pedal_zone == ptm_pkg::ZONE_COAST), m_torque_command == '0, "nonzero torque in rest or coast zone")

    // Saturation is symmetric, so the most negative code never appears.
    `PTM_ASSERT_SAME(a_symmetric_sat, aclk, aresetn, m_valid, !(m_torque_command[TW-1] && m_torque_command[TW-2:0] == '0), "torque outside symmetric range")

    // A stalled result beat holds its torque.
    `PTM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_torque_command), "result beat changed while stalled")

endmodule

bind pedal_to_torque_map ptm_checker u_ptm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_torque_command (m_torque_command),
    .m_pedal_zone     (m_pedal_zone)
);
